### sv/bitmap_pixel_to_console_texture_packer_macros.svh
// ----------------------------------------------------------------------------
// Texture packer assertion macros
// Shared concurrent assertion forms for the packer checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PIXEL_TO_CONSOLE_TEXTURE_PACKER_MACROS_SVH
`define BITMAP_PIXEL_TO_CONSOLE_TEXTURE_PACKER_MACROS_SVH

// checked only while out of reset
`define BPTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BPTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bptp_pkg.sv
// ----------------------------------------------------------------------------
// Texture packer package
// Types, codes and helpers shared by the pixel packer files.
// ----------------------------------------------------------------------------
package bptp_pkg;

    typedef enum logic [2:0] {
        SRC_IDX1   = 3'd0,
        SRC_IDX4   = 3'd1,
        SRC_IDX8   = 3'd2,
        SRC_RGB565 = 3'd3,
        SRC_BGR888 = 3'd4,
        SRC_XBGR32 = 3'd5
    } src_fmt_t;

    typedef enum logic [1:0] {
        OUT_PACK4   = 2'd0,
        OUT_PACK8   = 2'd1,
        OUT_COLOR15 = 2'd2,
        OUT_COLOR24 = 2'd3
    } out_mode_t;

    typedef enum logic [2:0] {
        CFG_SOURCE_FORMAT     = 3'd0,
        CFG_OUTPUT_MODE       = 3'd1,
        CFG_BLACK_TRANSPARENT = 3'd2,
        CFG_PINK_TRANSPARENT  = 3'd3,
        CFG_STP_ALWAYS        = 3'd4
    } cfg_idx_t;

    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [15:0] STP_BIT  = 16'h8000;
    localparam logic [15:0] PINK_555 = 16'h7c1f;

    typedef struct packed {
        src_fmt_t  source_format;
        out_mode_t output_mode;
        logic      black_transparent;
        logic      pink_transparent;
        logic      stp_always;
    } cfg_t;

    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  count;
        logic [23:0] held;
    } pack_state_t;

    typedef struct packed {
        logic [2:0][15:0] words;   // words[0] goes out first
        logic [1:0]       nwords;
    } fmt_out_t;

    function automatic logic [7:0] pixel_index(src_fmt_t fmt, logic [31:0] raw);
        logic [7:0] idx;
        idx = 8'd0;
        unique case (fmt)
            SRC_IDX1: idx = {7'd0, raw[0]};
            SRC_IDX4: idx = {4'd0, raw[3:0]};
            SRC_IDX8: idx = raw[7:0];
            default:  idx = 8'd0;
        endcase
        return idx;
    endfunction

endpackage

### sv/bptp_word_fmt.sv
// ----------------------------------------------------------------------------
// Texture word formatter
// Turns one staged pixel and the packing state into up to three texture words.
// ----------------------------------------------------------------------------
module bptp_word_fmt
    import bptp_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [31:0] raw,
    input  logic        eor,
    input  logic [23:0] pal_color,
    input  pack_state_t st,
    output fmt_out_t    res,
    output pack_state_t st_next
);

    logic [7:0]  idx;
    logic [23:0] color;
    logic [15:0] c15;
    logic [15:0] c_blk;
    logic [15:0] c_pink;
    logic [15:0] c_out;
    logic [15:0] or_word;
    logic [3:0]  shift;
    logic [2:0]  n;
    logic [23:0] c1;
    logic [23:0] c2;

    assign idx = pixel_index(cfg.source_format, raw);

    always_comb begin
        unique case (cfg.source_format)
            SRC_IDX1, SRC_IDX4, SRC_IDX8: color = pal_color;
            SRC_RGB565: color = {raw[15:11], 3'b000, raw[10:5], 2'b00, raw[4:0], 3'b000};
            SRC_BGR888: color = raw[23:0];
            SRC_XBGR32: color = raw[31:8];
            default:    color = 24'd0;
        endcase
    end

    // 5:5:5 conversion with transparency rules
    always_comb begin
        c15    = {1'b0, color[7:3], color[15:11], color[23:19]};
        c_blk  = (c15 == 16'd0 && !cfg.black_transparent) ? (c15 | STP_BIT) : c15;
        c_pink = (c_blk == PINK_555 && cfg.pink_transparent) ? 16'd0 : c_blk;
        if (cfg.stp_always &&
            !(cfg.black_transparent && c_pink == 16'd0) &&
            !(cfg.pink_transparent && c_pink == PINK_555)) begin
            c_out = c_pink | STP_BIT;
        end else begin
            c_out = c_pink;
        end
    end

    always_comb begin
        res     = '0;
        st_next = st;
        or_word = st.word;
        shift   = 4'd0;
        n       = 3'd0;
        c1      = 24'd0;
        c2      = 24'd0;
        unique case (cfg.output_mode)
            OUT_PACK4: begin
                shift   = {st.count, 2'b00};
                or_word = st.word | (16'(idx[3:0]) << shift);
                n       = {1'b0, st.count} + 3'd1;
                if (n == 3'd4 || eor) begin
                    res.words[0] = or_word;
                    res.nwords   = 2'd1;
                    st_next.word  = 16'd0;
                    st_next.count = 2'd0;
                end else begin
                    st_next.word  = or_word;
                    st_next.count = n[1:0];
                end
            end
            OUT_PACK8: begin
                shift   = {st.count[0], 3'b000};
                or_word = st.word | (16'(idx) << shift);
                n       = {2'b00, st.count[0]} + 3'd1;
                if (n == 3'd2 || eor) begin
                    res.words[0] = or_word;
                    res.nwords   = 2'd1;
                    st_next.word  = 16'd0;
                    st_next.count = 2'd0;
                end else begin
                    st_next.word  = or_word;
                    st_next.count = n[1:0];
                end
            end
            OUT_COLOR15: begin
                res.words[0] = c_out;
                res.nwords   = 2'd1;
            end
            default: begin
                if (st.count == 2'd0 && !eor) begin
                    st_next.held  = color;
                    st_next.count = 2'd1;
                end else begin
                    // lone pixel at end of row pairs with a zero pixel
                    c1 = (st.count == 2'd0) ? color : st.held;
                    c2 = (st.count == 2'd0) ? 24'd0 : color;
                    res.words[0] = {c1[15:8], c1[23:16]};
                    res.words[1] = {c2[23:16], c1[7:0]};
                    res.words[2] = {c2[7:0], c2[15:8]};
                    res.nwords   = 2'd3;
                    st_next.held  = 24'd0;
                    st_next.count = 2'd0;
                end
            end
        endcase
    end

endmodule

### sv/bitmap_pixel_to_console_texture_packer.sv
// ----------------------------------------------------------------------------
// Bitmap pixel to console texture packer
// Converts source pixels to 15/24-bit color or packed index texture words.
// ----------------------------------------------------------------------------
//   channel   dir   handshake            content
//   s_        in    s_tvalid/s_tready    pixel or palette write, row end on tlast
//   m_        out   m_tvalid/m_tready    16-bit texture word, tlast per item
//   cfg_      in    cfg_wr_en            register write, no read-back
//
// An input transfer is registered in the staging and palette read registers,
// then passes through the formatter into the output buffer. An item enters every
// cycle while the output buffer holds at most one word that drains; 24-bit
// mode emits three words per pixel pair and the held first pixel passes while
// the buffer runs empty, so there the input stalls as it drains. Reset clears
// control and packing state; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module bitmap_pixel_to_console_texture_packer
    import bptp_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pixel_raw[31:0], palette_slot[39:32], palette_color[63:40]
    input  logic        s_tuser,   // op
    input  logic        s_tlast,   // end_of_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_word[15:0]
    output logic        m_tlast,   // last_word
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [2:0]  cfg_wdata
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    cfg_t        cfg_reg;
    pack_state_t pack_reg;
    pack_state_t pack_next;
    fmt_out_t    fmt_res;

    logic [23:0] pal_mem [PALETTE_DEPTH];
    logic [23:0] pal_rd_reg;

    logic        s1_valid_reg;
    logic [31:0] s1_raw_reg;
    logic        s1_eor_reg;
    logic        s1_pal_ok_reg;

    logic [2:0][15:0] buf_reg;
    logic [1:0]       buf_cnt_reg;

    logic        s_xfer;
    logic        m_xfer;
    logic        buf_free;
    logic        s1_go;
    logic [7:0]  rd_idx;
    logic [7:0]  wr_slot;
    logic        wr_ok;
    logic        rd_ok;

    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;
    assign buf_free = (buf_cnt_reg == 2'd0) || (buf_cnt_reg == 2'd1 && m_tready);
    assign s1_go    = s1_valid_reg && buf_free;
    assign s_tready = !s1_valid_reg || s1_go;

    assign rd_idx  = pixel_index(cfg_reg.source_format, s_tdata[31:0]);
    assign wr_slot = s_tdata[39:32];
    assign rd_ok   = {1'b0, rd_idx} < 9'(PALETTE_DEPTH);
    assign wr_ok   = {1'b0, wr_slot} < 9'(PALETTE_DEPTH);

    // palette: one write or one read per transfer
    always_ff @(posedge aclk) begin
        if (s_xfer && s_tuser == OP_PALETTE && wr_ok) begin
            pal_mem[wr_slot[PAL_AW-1:0]] <= s_tdata[63:40];
        end
        if (s_xfer && s_tuser == OP_PIXEL) begin
            pal_rd_reg <= pal_mem[rd_idx[PAL_AW-1:0]];
        end
    end

    // staging register, palette writes end at the memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= (s_tuser == OP_PIXEL);
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_raw_reg    <= s_tdata[31:0];
            s1_eor_reg    <= s_tlast;
            s1_pal_ok_reg <= rd_ok;
        end
    end

    bptp_word_fmt u_fmt (
        .cfg       (cfg_reg),
        .raw       (s1_raw_reg),
        .eor       (s1_eor_reg),
        .pal_color (s1_pal_ok_reg ? pal_rd_reg : 24'd0),
        .st        (pack_reg),
        .res       (fmt_res),
        .st_next   (pack_next)
    );

    // configuration and packing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_format     <= SRC_BGR888;
            cfg_reg.output_mode       <= OUT_COLOR15;
            cfg_reg.black_transparent <= 1'b0;
            cfg_reg.pink_transparent  <= 1'b0;
            cfg_reg.stp_always        <= 1'b0;
            pack_reg                  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SOURCE_FORMAT:     cfg_reg.source_format     <= src_fmt_t'(cfg_wdata);
                CFG_OUTPUT_MODE: begin
                    cfg_reg.output_mode <= out_mode_t'(cfg_wdata[1:0]);
                    pack_reg            <= '0;
                end
                CFG_BLACK_TRANSPARENT: cfg_reg.black_transparent <= cfg_wdata[0];
                CFG_PINK_TRANSPARENT:  cfg_reg.pink_transparent  <= cfg_wdata[0];
                CFG_STP_ALWAYS:        cfg_reg.stp_always        <= cfg_wdata[0];
                default: ;
            endcase
        end else if (s1_go) begin
            pack_reg <= pack_next;
        end
    end

    // output buffer, shifts one word per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_cnt_reg <= 2'd0;
        end else if (s1_go) begin
            buf_cnt_reg <= fmt_res.nwords;
        end else if (m_xfer) begin
            buf_cnt_reg <= buf_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            buf_reg <= fmt_res.words;
        end else if (m_xfer) begin
            buf_reg <= {16'd0, buf_reg[2], buf_reg[1]};
        end
    end

    assign m_tvalid = (buf_cnt_reg != 2'd0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (buf_cnt_reg == 2'd1);

endmodule

### sv/bptp_checker.sv
// ----------------------------------------------------------------------------
// Texture packer port checker
// Watches the packer ports for buffer and stall behavior over time.
// ----------------------------------------------------------------------------
`include "bitmap_pixel_to_console_texture_packer_macros.svh"

module bptp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled word holds
    `BPTP_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output word changed")

    // words of one item follow without a gap
    `BPTP_ASSERT(a_group_gapless, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "gap inside a multi-word group")

    // input only backs up behind pending output
    `BPTP_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> m_tvalid, "input stalled with empty output")

    // nothing to send right after reset
    `BPTP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind bitmap_pixel_to_console_texture_packer bptp_checker u_bptp_checker (.*);
